/* src/swmam_pkg.sv */
// Shared types and constants for the sliding window min/avg/max unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package swmam_pkg;

    localparam int SAMPLE_W          = 16;
    localparam int CFG_W             = 7;
    localparam int INDEX_W           = 16;
    localparam int DEF_WINDOW_DEPTH  = 64;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [INDEX_W-1:0]         index_t;
    typedef logic [CFG_W-1:0]           cfg_t;

    // Per-cell control: shift a new request in, or rotate the ring.
    typedef struct packed {
        logic shift;
        logic rotate;
        logic wrap;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* src/sliding_window_min_avg_max_unit.sv */
// Top level of the sliding window min/avg/max unit: controller, cell chain,
// accumulators and output register.
// Depends on swmam_pkg, swmam_cell and swmam_div.
//
// Usage:
//   Input channel: sample_valid / sample_stall carry one Q8.8 sample per request.
//   Output channel: result_valid / result_stall carry sample_index, sample_echo,
//   window_min, window_avg and window_max for that sample.
//   The user writes window_size through window_size_we only while the unit is
//   idle; the unit itself does not enforce it. For each request the sum walks
//   W terms (W = effective window size) around a ring of cells, one per cycle,
//   and the average comes from a 16-step serial divider. Once W samples have
//   been seen these are the W newest samples; while fewer have been seen, the
//   ring is pre-aligned first and walked round its n samples (n = samples seen).
//   sample_stall is high from acceptance until the result is loaded into the
//   output register; the next request is taken while that result waits.
//   If result_stall holds the previous result, the finished request waits in
//   the controller and sample_stall stays high.
//   Reset clears the sample count, the running min/max and the output valid,
//   and sets the window size to 1.
`default_nettype none

module sliding_window_min_avg_max_unit #(
    parameter int WINDOW_DEPTH = swmam_pkg::DEF_WINDOW_DEPTH
) (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   window_size_we,
    input  swmam_pkg::cfg_t       window_size,
    input  wire                   sample_valid,
    output logic                  sample_stall,
    input  swmam_pkg::sample_t    sample,
    output logic                  result_valid,
    input  wire                   result_stall,
    output swmam_pkg::index_t     sample_index,
    output swmam_pkg::sample_t    sample_echo,
    output swmam_pkg::sample_t    window_min,
    output swmam_pkg::sample_t    window_avg,
    output swmam_pkg::sample_t    window_max
);
    import swmam_pkg::*;

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = SAMPLE_W + CNT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_SUM  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]          state_reg, state_next;
    cfg_t                wsize_reg, wsize_next;
    index_t              seen_reg, seen_next;
    sample_t             wmin_reg, wmin_next;
    sample_t             wmax_reg, wmax_next;
    logic [CNT_W-1:0]    win_reg, win_next;
    logic [CNT_W-1:0]    len_reg, len_next;
    logic [CNT_W-1:0]    rcnt_reg, rcnt_next;
    logic [CNT_W-1:0]    term_reg, term_next;
    logic                warm_reg, warm_next;
    sample_t             echo_reg, echo_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    sample_t             rmin_reg, rmin_next;
    sample_t             rmax_reg, rmax_next;
    logic                ovalid_reg, ovalid_next;
    index_t              oidx_reg, oidx_next;
    sample_t             oecho_reg, oecho_next;
    sample_t             omin_reg, omin_next;
    sample_t             oavg_reg, oavg_next;
    sample_t             omax_reg, omax_next;

    logic                accept;
    logic                rotate_en;
    logic                div_start;
    logic                div_done;
    sample_t             div_quot;
    logic [31:0]         wide_w;
    logic [CNT_W-1:0]    w_eff;
    logic [CNT_W-1:0]    len_m1;
    sample_t             head;
    sample_t             cell_data [WINDOW_DEPTH];

    assign accept = sample_valid && !sample_stall;
    assign head   = cell_data[0];
    assign len_m1 = len_reg - 1'b1;

    // Cell chain: new samples enter at cell 0; rotation moves toward cell 0
    // and closes the ring at the last in-window cell.
    for (genvar k = 0; k < WINDOW_DEPTH; k++)
    begin : g_cell
        cell_ctrl_t ctrl;
        sample_t    prev_d;
        sample_t    next_d;

        assign ctrl.shift  = accept;
        assign ctrl.rotate = rotate_en && (CNT_W'(k) < len_reg);
        assign ctrl.wrap   = (CNT_W'(k) == len_m1);

        if (k == 0)
        begin : g_first
            assign prev_d = sample;
        end
        else
        begin : g_inner
            assign prev_d = cell_data[k-1];
        end

        if (k == WINDOW_DEPTH - 1)
        begin : g_last
            assign next_d = cell_data[0];
        end
        else
        begin : g_mid
            assign next_d = cell_data[k+1];
        end

        swmam_cell u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .prev_data (prev_d),
            .next_data (next_d),
            .wrap_data (head),
            .data      (cell_data[k])
        );
    end

    swmam_div #(
        .DIV_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (win_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_comb
    begin
        wide_w = 32'(wsize_reg);
        if (wide_w == 32'd0)
        begin
            wide_w = 32'd1;
        end
        else if (wide_w > 32'(WINDOW_DEPTH))
        begin
            wide_w = 32'(WINDOW_DEPTH);
        end
        w_eff = CNT_W'(wide_w);
    end

    always_comb
    begin
        state_next  = state_reg;
        wsize_next  = window_size_we ? window_size : wsize_reg;
        seen_next   = seen_reg;
        wmin_next   = wmin_reg;
        wmax_next   = wmax_reg;
        win_next    = win_reg;
        len_next    = len_reg;
        rcnt_next   = rcnt_reg;
        term_next   = term_reg;
        warm_next   = warm_reg;
        echo_next   = echo_reg;
        sum_next    = sum_reg;
        rmin_next   = rmin_reg;
        rmax_next   = rmax_reg;
        ovalid_next = ovalid_reg && result_stall;
        oidx_next   = oidx_reg;
        oecho_next  = oecho_reg;
        omin_next   = omin_reg;
        oavg_next   = oavg_reg;
        omax_next   = omax_reg;
        rotate_en   = 1'b0;
        div_start   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (seen_reg == '0)
                    begin
                        wmin_next = sample;
                        wmax_next = sample;
                    end
                    else
                    begin
                        if (sample < wmin_reg)
                        begin
                            wmin_next = sample;
                        end
                        if (sample > wmax_reg)
                        begin
                            wmax_next = sample;
                        end
                    end
                    seen_next = (seen_reg == '1) ? seen_reg : seen_reg + 1'b1;
                    warm_next = (seen_next <= INDEX_W'(w_eff));
                    len_next  = warm_next ? CNT_W'(seen_next) : w_eff;
                    win_next  = w_eff;
                    rcnt_next = w_eff;
                    echo_next = sample;
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                // Align the ring so the walk starts len - (W mod len) samples back from the newest.
                if (rcnt_reg >= len_reg)
                begin
                    rcnt_next = rcnt_reg - len_reg;
                end
                else if (rcnt_reg == '0)
                begin
                    term_next  = '0;
                    state_next = ST_SUM;
                end
                else
                begin
                    rotate_en = 1'b1;
                    rcnt_next = rcnt_reg + 1'b1;
                end
            end
            ST_SUM:
            begin
                rotate_en = 1'b1;
                if (term_reg == '0)
                begin
                    sum_next  = SUM_W'(head);
                    rmin_next = head;
                    rmax_next = head;
                end
                else
                begin
                    sum_next = sum_reg + SUM_W'(head);
                    if (head < rmin_reg)
                    begin
                        rmin_next = head;
                    end
                    if (head > rmax_reg)
                    begin
                        rmax_next = head;
                    end
                end
                term_next = term_reg + 1'b1;
                if (term_reg == win_reg - 1'b1)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!ovalid_reg || !result_stall)
                begin
                    ovalid_next = 1'b1;
                    oidx_next   = seen_reg;
                    oecho_next  = echo_reg;
                    omin_next   = warm_reg ? wmin_reg : rmin_reg;
                    omax_next   = warm_reg ? wmax_reg : rmax_reg;
                    oavg_next   = div_quot;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wsize_reg  <= CFG_W'(1);
            seen_reg   <= '0;
            wmin_reg   <= '0;
            wmax_reg   <= '0;
            win_reg    <= CNT_W'(1);
            len_reg    <= CNT_W'(1);
            rcnt_reg   <= '0;
            term_reg   <= '0;
            warm_reg   <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wsize_reg  <= wsize_next;
            seen_reg   <= seen_next;
            wmin_reg   <= wmin_next;
            wmax_reg   <= wmax_next;
            win_reg    <= win_next;
            len_reg    <= len_next;
            rcnt_reg   <= rcnt_next;
            term_reg   <= term_next;
            warm_reg   <= warm_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        echo_reg  <= echo_next;
        sum_reg   <= sum_next;
        rmin_reg  <= rmin_next;
        rmax_reg  <= rmax_next;
        oidx_reg  <= oidx_next;
        oecho_reg <= oecho_next;
        omin_reg  <= omin_next;
        oavg_reg  <= oavg_next;
        omax_reg  <= omax_next;
    end

    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = ovalid_reg;
    assign sample_index = oidx_reg;
    assign sample_echo  = oecho_reg;
    assign window_min   = omin_reg;
    assign window_avg   = oavg_reg;
    assign window_max   = omax_reg;

endmodule

`default_nettype wire

/* src/swmam_cell.sv */
// One storage cell of the sample chain: holds one sample.
// Depends on swmam_pkg.
`default_nettype none

module swmam_cell (
    input  wire                     clk,
    input  swmam_pkg::cell_ctrl_t   ctrl,
    input  swmam_pkg::sample_t      prev_data,
    input  swmam_pkg::sample_t      next_data,
    input  swmam_pkg::sample_t      wrap_data,
    output swmam_pkg::sample_t      data
);
    import swmam_pkg::*;

    sample_t data_reg;
    sample_t data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = prev_data;
        end
        else if (ctrl.rotate)
        begin
            data_next = ctrl.wrap ? wrap_data : next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

/* src/swmam_div.sv */
// Bit-serial signed divider for the window average, one quotient bit a cycle.
// Depends on swmam_pkg.
`default_nettype none

module swmam_div #(
    parameter int DIV_W = 7
) (
    input  wire                                          clk,
    input  wire                                          rst_n,
    input  wire                                          start,
    input  wire signed [swmam_pkg::SAMPLE_W+DIV_W-1:0]   dividend,
    input  wire        [DIV_W-1:0]                       divisor,
    output logic                                         done,
    output swmam_pkg::sample_t                           quotient
);
    import swmam_pkg::*;

    localparam int DVD_W  = SAMPLE_W + DIV_W;
    localparam int STEP_W = $clog2(SAMPLE_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    logic [DIV_W-1:0]      rem_reg, rem_next;
    logic [SAMPLE_W-1:0]   q_reg, q_next;
    logic [DIV_W-1:0]      dsr_reg, dsr_next;
    logic                  neg_reg, neg_next;
    logic [DVD_W-1:0]      mag;
    logic [DIV_W:0]        trial;
    logic [DIV_W:0]        diff;

    always_comb
    begin
        mag   = dividend[DVD_W-1] ? DVD_W'(-dividend) : DVD_W'(dividend);
        trial = {rem_reg, q_reg[SAMPLE_W-1]};
        diff  = trial - {1'b0, dsr_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;

        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = mag[DVD_W-1:SAMPLE_W];
            q_next    = mag[SAMPLE_W-1:0];
            dsr_next  = divisor;
            neg_next  = dividend[DVD_W-1];
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[DIV_W-1:0];
                q_next   = {q_reg[SAMPLE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
                q_next   = {q_reg[SAMPLE_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(SAMPLE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? sample_t'(-q_reg) : sample_t'(q_reg);

endmodule

`default_nettype wire

/* dv/sliding_window_min_avg_max_checker.sv */
// Checker for the sliding window min/avg/max unit: predicts each result and compares it.
// Watches the request, result and window_size ports; depends on swmam_pkg.
`timescale 1ns / 100ps

module sliding_window_min_avg_max_checker #(
    parameter int WINDOW_DEPTH = swmam_pkg::DEF_WINDOW_DEPTH
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 window_size_we,
    input  swmam_pkg::cfg_t     window_size,
    input  wire                 sample_valid,
    input  wire                 sample_stall,
    input  swmam_pkg::sample_t  sample,
    input  wire                 result_valid,
    input  wire                 result_stall,
    input  swmam_pkg::index_t   sample_index,
    input  swmam_pkg::sample_t  sample_echo,
    input  swmam_pkg::sample_t  window_min,
    input  swmam_pkg::sample_t  window_avg,
    input  swmam_pkg::sample_t  window_max,
    output int                  mismatches,
    output int                  outstanding,
    output int                  checked
);
    import swmam_pkg::*;

    typedef struct packed {
        index_t  index;
        sample_t echo;
        sample_t lowest;
        sample_t mean;
        sample_t highest;
    } window_stats_t;

    window_stats_t stats_due[$];

    cfg_t    cfg_window;
    sample_t ring[WINDOW_DEPTH];
    int      wr_ptr;
    int      seen;
    sample_t run_min;
    sample_t run_max;

    function automatic window_stats_t advance_window(input sample_t s);
        window_stats_t r;
        int            w;
        int            n;
        int            sum;
        int            c;
        int            t;
        sample_t       v;
        w = (cfg_window == '0) ? 1 :
            ((cfg_window > WINDOW_DEPTH) ? WINDOW_DEPTH : int'(cfg_window));
        if (seen == 0)
        begin
            run_min = s;
            run_max = s;
        end
        else
        begin
            if (s < run_min)
                run_min = s;
            if (s > run_max)
                run_max = s;
        end
        ring[wr_ptr] = s;
        wr_ptr = (wr_ptr + 1) % WINDOW_DEPTH;
        if (seen < 65535)
            seen++;
        n = seen;
        sum = 0;
        if (n <= w)
        begin
            r.lowest  = run_min;
            r.highest = run_max;
            c = 0;
            for (t = 0; t < w; t++)
            begin
                sum += ring[(wr_ptr + WINDOW_DEPTH - n + c) % WINDOW_DEPTH];
                c++;
                if (c >= n)
                    c = 0;
            end
        end
        else
        begin
            r.lowest  = s;
            r.highest = s;
            for (t = 0; t < w; t++)
            begin
                v = ring[(wr_ptr + WINDOW_DEPTH - w + t) % WINDOW_DEPTH];
                if (v < r.lowest)
                    r.lowest = v;
                if (v > r.highest)
                    r.highest = v;
                sum += v;
            end
        end
        r.index = index_t'(n);
        r.echo  = s;
        r.mean  = sample_t'(sum / w);
        return r;
    endfunction

    function automatic void check_field(input string field, input integer want,
                                        input integer got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        window_stats_t got;
        window_stats_t want;
        if (!rst_n)
        begin
            cfg_window = 7'd1;
            wr_ptr     = 0;
            seen       = 0;
            run_min    = '0;
            run_max    = '0;
            mismatches = 0;
            checked    = 0;
            stats_due.delete();
        end
        else
        begin
            if (window_size_we)
                cfg_window = window_size;
            if (sample_valid && !sample_stall)
                stats_due.push_back(advance_window(sample));
            if (result_valid && !result_stall)
            begin
                got = '{sample_index, sample_echo, window_min, window_avg, window_max};
                if (stats_due.size() == 0)
                begin
                    $error("result index %0d with no request outstanding", sample_index);
                    mismatches++;
                end
                else
                begin
                    want = stats_due.pop_front();
                    check_field("sample_index", want.index, got.index);
                    check_field("sample_echo", want.echo, got.echo);
                    check_field("window_min", want.lowest, got.lowest);
                    check_field("window_avg", want.mean, got.mean);
                    check_field("window_max", want.highest, got.highest);
                    checked++;
                end
            end
        end
        outstanding = stats_due.size();
    end

endmodule

/* dv/sliding_window_min_avg_max_unit_test.sv */
// Testbench top for sliding_window_min_avg_max_unit: clock, reset, stimulus and verdict.
// Depends on swmam_pkg, the unit and sliding_window_min_avg_max_checker.
`timescale 1ns / 100ps

module sliding_window_min_avg_max_unit_test;

    import swmam_pkg::*;

    localparam sample_t Q_MAX        = 16'sh7FFF;
    localparam sample_t Q_MIN        = 16'sh8000;
    localparam int      PHASE_ITEMS  = 460;
    localparam int      HOLD_CYCLES  = 600;
    localparam int      DRAIN_CYCLES = 200;

    logic    clk            = 1'b0;
    logic    rst_n          = 1'b0;
    logic    window_size_we = 1'b0;
    cfg_t    window_size    = '0;
    logic    sample_valid   = 1'b0;
    sample_t sample         = '0;
    logic    result_stall   = 1'b0;

    logic    sample_stall;
    logic    result_valid;
    index_t  sample_index;
    sample_t sample_echo;
    sample_t window_min;
    sample_t window_avg;
    sample_t window_max;

    int      mismatches;
    int      outstanding;
    int      checked;

    int unsigned snd_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    logic        hold_req     = 1'b0;
    int          issued       = 0;
    int          window_writes = 0;
    int          holds        = 0;

    sliding_window_min_avg_max_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .window_size_we (window_size_we),
        .window_size    (window_size),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .sample_index   (sample_index),
        .sample_echo    (sample_echo),
        .window_min     (window_min),
        .window_avg     (window_avg),
        .window_max     (window_max)
    );

    sliding_window_min_avg_max_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .window_size_we (window_size_we),
        .window_size    (window_size),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .sample_index   (sample_index),
        .sample_echo    (sample_echo),
        .window_min     (window_min),
        .window_avg     (window_avg),
        .window_max     (window_max),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .checked        (checked)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin : watchdog
        #300_000_000;
        $display("sliding_window_min_avg_max_unit: mismatch");
        $finish;
    end

    // hold the output off for a long stretch on request, otherwise stall at random
    initial
    begin : result_side
        int hold_left;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                result_stall <= 1'b1;
                for (hold_left = HOLD_CYCLES; hold_left > 1; hold_left--)
                    @(posedge clk);
                hold_req = 1'b0;
            end
            else
                result_stall <= ($urandom_range(99) < rcv_idle_pct);
        end
    end

    task automatic push_sample(input sample_t s);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            sample_valid <= 1'b0;
            @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= s;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        issued++;
    endtask

    task automatic drain_results();
        sample_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input cfg_t value);
        window_size_we <= 1'b1;
        window_size    <= value;
        @(posedge clk);
        window_size_we <= 1'b0;
        window_writes++;
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(9))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2, 3:    return sample_t'(int'($urandom_range(512)) - 256);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic cfg_t pick_window();
        case ($urandom_range(7))
            0:       return '0;
            1:       return 7'd1;
            2:       return 7'd64;
            3:       return 7'd127;
            4:       return cfg_t'($urandom_range(8, 2));
            default: return cfg_t'($urandom_range(127));
        endcase
    endfunction

    initial
    begin : stimulus
        int      phase;
        int      segment;
        int      sent;
        int      len;
        int      k;
        logic    flat;
        sample_t flat_value;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // window of one from reset, then resized to 4, 0, 127 and 3 across warm-up and steady state
        push_sample(Q_MAX);
        push_sample(Q_MIN);
        drain_results();
        write_window(7'd4);
        push_sample(16'shFFFF);
        push_sample(16'sh0001);
        push_sample(16'sh5555);
        push_sample(16'shAAAA);
        drain_results();
        write_window(7'd0);
        push_sample(16'sh0000);
        push_sample(Q_MIN);
        drain_results();
        write_window(7'd127);
        push_sample(Q_MAX);
        push_sample(16'sh0100);
        push_sample(16'shFF00);
        push_sample(16'sh0080);
        push_sample(16'sh8001);
        push_sample(16'sh7FFE);
        push_sample(16'sh0002);
        push_sample(16'shFFFE);
        drain_results();
        write_window(7'd3);
        push_sample(16'sh0001);
        push_sample(16'sh0002);
        push_sample(16'sh0003);

        segment = 0;
        for (phase = 0; phase < 3; phase++)
        begin
            drain_results();
            case (phase)
                0:
                begin
                    snd_idle_pct = 21;
                    rcv_idle_pct = 78;
                end
                1:
                begin
                    snd_idle_pct = 78;
                    rcv_idle_pct = 21;
                end
                default:
                begin
                    snd_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                drain_results();
                write_window(segment == 0 ? cfg_t'(7'd64) : pick_window());
                len = (segment == 0) ? 80 : int'($urandom_range(80, 10));
                flat = ($urandom_range(7) == 0);
                flat_value = $urandom_range(1) ? Q_MAX : Q_MIN;
                if (segment % 7 == 3)
                begin
                    hold_req = 1'b1;
                    holds++;
                end
                for (k = 0; k < len; k++)
                    push_sample(flat ? flat_value : pick_sample());
                sent += len;
                segment++;
            end
        end

        // widest window over a settled stream, then a short one
        drain_results();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_window(7'd127);
        for (k = 0; k < 80; k++)
            push_sample(pick_sample());
        drain_results();
        write_window(7'd5);
        for (k = 0; k < 20; k++)
            push_sample(pick_sample());
        drain_results();

        $display("checked %0d results across %0d window_size writes, warm-up and steady state",
                 checked, window_writes);
        $display("output held off %0d times while requests kept coming", holds);
        if (mismatches == 0)
            $display("sliding_window_min_avg_max_unit: match");
        else
            $display("sliding_window_min_avg_max_unit: mismatch");
        $finish;
    end

endmodule

/* sliding_window_min_avg_max_unit.f */
src/swmam_pkg.sv
src/swmam_cell.sv
src/swmam_div.sv
src/sliding_window_min_avg_max_unit.sv
dv/sliding_window_min_avg_max_checker.sv
dv/sliding_window_min_avg_max_unit_test.sv
